>>> design/rmt_pkg.sv
// Shared types and constants for the running median tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rmt_pkg;

    localparam int RMT_CAPACITY   = 1024;
    localparam int RMT_DATA_WIDTH = 32;
    localparam int RMT_SAMPLE_W   = 32;
    localparam int RMT_MEDIAN_W   = 33;
    localparam int RMT_COUNT_W    = 11;

    // Operation broadcast to every cell of a sorted chain
    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // What one sample does to the two halves
    typedef enum logic [2:0] {
        PLAN_DROP     = 3'd0,
        PLAN_LOW_PUSH = 3'd1,
        PLAN_UP_PUSH  = 3'd2,
        PLAN_LOW_SWAP = 3'd3,
        PLAN_UP_SWAP  = 3'd4
    } plan_t;

endpackage
`default_nettype wire

>>> design/running_median_tracker_unit.sv
// Top level of the running median tracker: control sequencer, two sorted chains,
// result register. Depends on rmt_pkg, rmt_chain (and through it rmt_cell).
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+----------------------------------
//   sample  | sample_valid | sample_stall | sample[31:0]
//   result  | result_valid | result_stall | median_twice[32:0], count, dropped
//
// Each item goes through these steps from its transfer to its result being
// loaded: transfer, plan, first chain step, second chain step, result load.
// Two chain steps are needed since a move of a top across the halves pops one
// chain and pushes the other, then the sample is pushed. A new sample is taken
// only once the last result is loaded; a stalled result holds the sequencer in
// its load step. Reset clears the chain counts and sequencer at once; no sweep.
`timescale 1ns / 1ps
`default_nettype none
module running_median_tracker_unit
    import rmt_pkg::*;
#(
    parameter int CAPACITY   = RMT_CAPACITY,
    parameter int DATA_WIDTH = RMT_DATA_WIDTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [RMT_SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic signed [RMT_MEDIAN_W-1:0]      median_twice,
    output logic [RMT_COUNT_W-1:0]              count,
    output logic                                dropped
);

    localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
    localparam int UPPER_DEPTH = CAPACITY / 2;
    localparam int LSW         = $clog2(LOWER_DEPTH + 1);
    localparam int USW         = $clog2(UPPER_DEPTH + 1);
    localparam int CW          = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PLAN   = 5'b00010,
        ST_STEP1  = 5'b00100,
        ST_STEP2  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    plan_t                   plan_reg;
    plan_t                   plan_next;
    logic [DATA_WIDTH-1:0]   value_reg;

    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [RMT_MEDIAN_W-1:0] median_reg;
    logic [RMT_COUNT_W-1:0]  count_reg;
    logic                    dropped_reg;

    op_t                     lower_op;
    op_t                     upper_op;
    logic [DATA_WIDTH-1:0]   lower_push;
    logic [DATA_WIDTH-1:0]   upper_push;
    logic [DATA_WIDTH-1:0]   lower_head;
    logic [DATA_WIDTH-1:0]   upper_head;
    logic [LSW-1:0]          lower_size;
    logic [USW-1:0]          upper_size;

    logic [CW-1:0]           total;
    logic [CW:0]             total_inc;
    logic [CW:0]             lower_goal;
    logic [CW:0]             upper_goal;
    logic                    joins_lower;
    logic                    full;
    logic                    load_result;
    logic [RMT_MEDIAN_W-1:0] lower_ext;
    logic [RMT_MEDIAN_W-1:0] upper_ext;
    logic [RMT_MEDIAN_W-1:0] median_calc;
    logic [CW+RMT_COUNT_W-1:0] total_wide;

    // Lower half: largest at the head. Upper half: smallest at the head.
    rmt_chain #(
        .DEPTH      (LOWER_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IS_MAX     (1'b1)
    ) u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (lower_op),
        .push_data (lower_push),
        .head      (lower_head),
        .size      (lower_size)
    );

    rmt_chain #(
        .DEPTH      (UPPER_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IS_MAX     (1'b0)
    ) u_upper (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (upper_op),
        .push_data (upper_push),
        .head      (upper_head),
        .size      (upper_size)
    );

    // Occupancy and the split that the next value must leave
    assign total      = CW'(lower_size) + CW'(upper_size);
    assign total_inc  = {1'b0, total} + (CW+1)'(1);
    assign lower_goal = (total_inc + (CW+1)'(1)) >> 1;
    assign upper_goal = total_inc >> 1;
    assign full       = (total >= CW'(CAPACITY));
    assign joins_lower = (total == '0) || ($signed(value_reg) <= $signed(lower_head));

    // Plan the moves for the held sample
    always_comb
    begin
        if (full)
            plan_next = PLAN_DROP;
        else if (joins_lower)
        begin
            if ((CW+1)'(lower_size) >= lower_goal)
                plan_next = PLAN_LOW_SWAP;
            else
                plan_next = PLAN_LOW_PUSH;
        end
        else if ((CW+1)'(upper_size) >= upper_goal)
        begin
            // the smaller of the upper top and the sample moves down
            if ((upper_size != '0) && ($signed(upper_head) < $signed(value_reg)))
                plan_next = PLAN_UP_SWAP;
            else
                plan_next = PLAN_LOW_PUSH;
        end
        else
            plan_next = PLAN_UP_PUSH;
    end

    // Drive the chains: first step does the single push or the move across,
    // second step pushes the sample after a move.
    always_comb
    begin
        lower_op   = OP_NOP;
        upper_op   = OP_NOP;
        lower_push = value_reg;
        upper_push = value_reg;
        if (state_reg == ST_STEP1)
        begin
            case (plan_reg)
                PLAN_LOW_PUSH: lower_op = OP_PUSH;
                PLAN_UP_PUSH:  upper_op = OP_PUSH;
                PLAN_LOW_SWAP:
                begin
                    lower_op   = OP_POP;
                    upper_op   = OP_PUSH;
                    upper_push = lower_head;
                end
                PLAN_UP_SWAP:
                begin
                    upper_op   = OP_POP;
                    lower_op   = OP_PUSH;
                    lower_push = upper_head;
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_STEP2)
        begin
            case (plan_reg)
                PLAN_LOW_SWAP: lower_op = OP_PUSH;
                PLAN_UP_SWAP:  upper_op = OP_PUSH;
                default: ;
            endcase
        end
    end

    // Doubled median from the two heads
    assign lower_ext = {{(RMT_MEDIAN_W-DATA_WIDTH){lower_head[DATA_WIDTH-1]}}, lower_head};
    assign upper_ext = {{(RMT_MEDIAN_W-DATA_WIDTH){upper_head[DATA_WIDTH-1]}}, upper_head};

    always_comb
    begin
        if (total[0] || (upper_size == '0))
            median_calc = lower_ext << 1;
        else
            median_calc = lower_ext + upper_ext;
    end

    assign total_wide = {{RMT_COUNT_W{1'b0}}, total};

    // Load the result once the output register is free or being drained
    assign load_result = (state_reg == ST_RESULT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = (sample_valid) ? ST_PLAN : ST_IDLE;
            ST_PLAN:   state_next = ST_STEP1;
            ST_STEP1:  state_next = ST_STEP2;
            ST_STEP2:  state_next = ST_RESULT;
            ST_RESULT: state_next = (load_result) ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: hold the sample, the plan and the result
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && sample_valid)
            value_reg <= sample[DATA_WIDTH-1:0];
        if (state_reg == ST_PLAN)
            plan_reg <= plan_next;
        if (load_result)
        begin
            median_reg  <= median_calc;
            count_reg   <= total_wide[RMT_COUNT_W-1:0];
            dropped_reg <= (plan_reg == PLAN_DROP);
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign median_twice = median_reg;
    assign count        = count_reg;
    assign dropped      = dropped_reg;

endmodule
`default_nettype wire

>>> design/rmt_cell.sv
// One storage cell of a sorted chain: holds a value, shifts with its neighbours.
// Depends on rmt_pkg (op_t).
`timescale 1ns / 1ps
`default_nettype none
module rmt_cell
    import rmt_pkg::*;
#(
    parameter int DATA_WIDTH = RMT_DATA_WIDTH,
    parameter bit IS_MAX     = 1'b0
)
(
    input  wire logic                  clk,
    input  wire op_t                   op,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic                  tail,
    input  wire logic                  left_ins,
    input  wire logic [DATA_WIDTH-1:0] left_val,
    input  wire logic [DATA_WIDTH-1:0] right_val,
    output logic                       ins,
    output logic [DATA_WIDTH-1:0]      val
);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] val_next;
    logic                  ahead;

    // new value belongs in front of the one held here
    always_comb
    begin
        if (IS_MAX)
            ahead = $signed(push_data) > $signed(val_reg);
        else
            ahead = $signed(push_data) < $signed(val_reg);
    end

    assign ins = ahead || tail;
    assign val = val_reg;

    always_comb
    begin
        case (op)
            OP_PUSH:
            begin
                if (left_ins)
                    val_next = left_val;
                else if (ins)
                    val_next = push_data;
                else
                    val_next = val_reg;
            end
            OP_POP:  val_next = right_val;
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

>>> design/rmt_chain.sv
// Sorted chain of rmt_cell instances with its occupancy count; head is the top.
// Depends on rmt_pkg and rmt_cell.
`timescale 1ns / 1ps
`default_nettype none
module rmt_chain
    import rmt_pkg::*;
#(
    parameter int  DEPTH      = RMT_CAPACITY / 2,
    parameter int  DATA_WIDTH = RMT_DATA_WIDTH,
    parameter bit  IS_MAX     = 1'b0,
    localparam int SW         = $clog2(DEPTH + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire op_t                   op,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    output logic [DATA_WIDTH-1:0]      head,
    output logic [SW-1:0]              size
);

    logic [SW-1:0]         size_reg;
    logic [SW-1:0]         size_next;
    logic [DEPTH-1:0]      ins_w;
    logic [DEPTH-1:0]      tail_w;
    logic [DATA_WIDTH-1:0] val_w [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                  left_ins;
            logic [DATA_WIDTH-1:0] left_val;
            logic [DATA_WIDTH-1:0] right_val;

            assign tail_w[i] = (size_reg == SW'(i));

            if (i == 0)
            begin : g_first
                assign left_ins = 1'b0;
                assign left_val = push_data;
            end
            else
            begin : g_inner_l
                assign left_ins = ins_w[i-1];
                assign left_val = val_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_val = push_data;
            end
            else
            begin : g_inner_r
                assign right_val = val_w[i+1];
            end

            rmt_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IS_MAX     (IS_MAX)
            ) u_cell (
                .clk       (clk),
                .op        (op),
                .push_data (push_data),
                .tail      (tail_w[i]),
                .left_ins  (left_ins),
                .left_val  (left_val),
                .right_val (right_val),
                .ins       (ins_w[i]),
                .val       (val_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        case (op)
            OP_PUSH: size_next = size_reg + SW'(1);
            OP_POP:  size_next = size_reg - SW'(1);
            default: size_next = size_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= '0;
        else
            size_reg <= size_next;
    end

    assign head = val_w[0];
    assign size = size_reg;

endmodule
`default_nettype wire

>>> design/rmt_checker.sv
// Port-level checker for running_median_tracker_unit, bound to the top level.
// Depends on rmt_pkg for its default parameter and its port widths.
`timescale 1ns / 1ps
`default_nettype none
module rmt_checker
    import rmt_pkg::*;
#(
    parameter int CAPACITY = RMT_CAPACITY
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    sample_valid,
    input wire logic                    sample_stall,
    input wire logic                    result_valid,
    input wire logic                    result_stall,
    input wire logic [RMT_MEDIAN_W-1:0] median_twice,
    input wire logic [RMT_COUNT_W-1:0]  count,
    input wire logic                    dropped
);

    localparam int CAPW = $clog2(CAPACITY + 1) + RMT_COUNT_W;
    localparam logic [CAPW-1:0] CAP_WIDE = CAPW'(CAPACITY);

    // a stalled result stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(median_twice) && $stable(count) && $stable(dropped))
        else $error("result payload changed while stalled");

    // one item at a time: the input closes right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("second sample taken during processing");

    // a drop only happens on a full store
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && dropped |-> count == CAP_WIDE[RMT_COUNT_W-1:0])
        else $error("sample dropped below capacity");

    // every result describes a store holding at least one value
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (count != '0) || (CAPACITY >= (1 << RMT_COUNT_W)))
        else $error("result reports an empty store");

endmodule

bind running_median_tracker_unit rmt_checker #(
    .CAPACITY (CAPACITY)
) u_rmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .median_twice (median_twice),
    .count        (count),
    .dropped      (dropped)
);
`default_nettype wire

>>> sim/running_median_tracker_unit_tb.sv
// Self-checking testbench for running_median_tracker_unit: directed extremes, then random
// samples that fill the store and run on into dropped samples. Depends on rmt_pkg and the RTL.
`timescale 1ns / 1ps
module running_median_tracker_unit_tb;
    import rmt_pkg::*;

    localparam int RANDOM_ITEMS = 1725;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 20;     // extra wait for any stray result after the drain
    localparam int DIRECTED_N   = 22;

    typedef struct packed {
        logic signed [RMT_MEDIAN_W-1:0] med2;
        logic [RMT_COUNT_W-1:0]         cnt;
        logic                           drop;
    } median_result_t;

    typedef struct packed {
        logic [RMT_SAMPLE_W-1:0] value;
        logic                    typed;
        median_result_t          want;
    } stim_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SCATTER,
        STALL_LONG
    } stall_mode_e;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    logic signed [RMT_SAMPLE_W-1:0]      sample       = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic signed [RMT_MEDIAN_W-1:0]      median_twice;
    logic [RMT_COUNT_W-1:0]              count;
    logic                                dropped;

    // Travels alongside the sample payload: a row whose result is typed in the table
    logic                                row_typed = 1'b0;
    median_result_t                      row_want  = '0;

    // Predictor state: every held sample in ascending order. The two chains of the block
    // always split this list at its middle, so the tops are the middle entries.
    logic signed [RMT_SAMPLE_W-1:0]      held_sorted [$];
    median_result_t                      pending_medians [$];
    int                                  outstanding = 0;
    int                                  results_seen = 0;
    int                                  mismatches = 0;
    int                                  idle_cycles = 0;
    int                                  burst_left = 0;
    stall_mode_e                         stall_mode = STALL_NONE;
    int                                  stall_left = 0;
    int                                  stall_run = 0;
    logic signed [RMT_SAMPLE_W-1:0]      centre = '0;
    logic signed [RMT_SAMPLE_W-1:0]      last_value = '0;
    stim_row_t                           directed_rows [0:DIRECTED_N-1];

    running_median_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .median_twice (median_twice),
        .count        (count),
        .dropped      (dropped)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, field, got, want);
        mismatches++;
    endtask

    // Insert one sample into the ordered list (unless the store is full) and work out
    // the doubled median: twice the middle entry for an odd count, else the two middles.
    function automatic median_result_t track_median(input logic signed [RMT_SAMPLE_W-1:0] v);
        median_result_t r;
        int             pos;
        int             n;
        longint         lo;
        longint         sum;
        r.drop = 1'b0;
        if (held_sorted.size() >= RMT_CAPACITY)
            r.drop = 1'b1;
        else
        begin
            pos = 0;
            while (pos < held_sorted.size() && held_sorted[pos] <= v)
                pos++;
            held_sorted.insert(pos, v);
        end
        n  = held_sorted.size();
        lo = held_sorted[(n - 1) / 2];
        if (n % 2 == 1)
            sum = 2 * lo;
        else
            sum = lo + longint'(held_sorted[n / 2]);
        r.med2 = sum[RMT_MEDIAN_W-1:0];
        r.cnt  = n[RMT_COUNT_W-1:0];
        return r;
    endfunction

    // Mix of full-range values, extremes, values near zero, clusters round a drifting
    // centre (duplicates, close calls against chain tops) and repeats of the last sample.
    function automatic logic signed [RMT_SAMPLE_W-1:0] pick_sample();
        logic signed [RMT_SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3:
            begin
                case ($urandom_range(0, 6))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 32'sh8000_0001;
                    3:       v = 32'sh7FFF_FFFE;
                    4:       v = -32'sd1;
                    5:       v = 32'sd1;
                    default: v = '0;
                endcase
            end
            4, 5, 6: v = centre + $signed($urandom_range(0, 16)) - 32'sd8;
            7, 8:    v = $signed($urandom_range(0, 200)) - 32'sd100;
            default: v = last_value;
        endcase
        return v;
    endfunction

    // Sender: bursts of random length, random gaps between them, some gaps of zero so
    // that long back-to-back stretches occur.
    task automatic send_sample(input logic [RMT_SAMPLE_W-1:0] value, input logic typed,
                               input median_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= value;
        row_typed    <= typed;
        row_want     <= want;
        last_value    = value;
        // Hold the payload until the transfer happens
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic hold_until_drained();
        sample_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Receiver: stretches with no stall, scattered single stalls, and long stall runs
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 2));
            stall_left <= $urandom_range(20, 150);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:    result_stall <= 1'b0;
            STALL_SCATTER: result_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    result_stall <= ~result_stall;
                    stall_run    <= $urandom_range(1, 20);
                end
                else
                    stall_run <= stall_run - 1;
            end
        endcase
    end

    // Monitor: predict on each sample transfer, check each result transfer in order
    always @(posedge clk)
    begin
        median_result_t predicted;
        median_result_t want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                predicted = track_median(sample);
                // A typed-in table row overrides the predictor for the comparison
                if (row_typed)
                    predicted = row_want;
                pending_medians.insert(pending_medians.size(), predicted);
                outstanding++;
            end
            if (result_valid && !result_stall)
            begin
                if (outstanding == 0)
                    report_mismatch("result with nothing expected, median_twice",
                                    longint'(median_twice), 0);
                else
                begin
                    want = pending_medians.pop_front();
                    outstanding--;
                    if (median_twice !== want.med2)
                        report_mismatch("median_twice", longint'(median_twice),
                                        longint'(want.med2));
                    if (count !== want.cnt)
                        report_mismatch("count", longint'(count), longint'(want.cnt));
                    if (dropped !== want.drop)
                        report_mismatch("dropped", longint'(dropped), longint'(want.drop));
                end
                results_seen++;
            end
        end
    end

    // Watchdog: end the run once nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        median_result_t none;
        none = '0;

        // Extremes on an empty store: results follow straight from the ordered set
        directed_rows[0]  = '{32'h8000_0000, 1'b1, '{33'h1_0000_0000, 11'd1, 1'b0}};
        directed_rows[1]  = '{32'h7FFF_FFFF, 1'b1, '{33'h1_FFFF_FFFF, 11'd2, 1'b0}};
        directed_rows[2]  = '{32'h7FFF_FFFF, 1'b1, '{33'h0_FFFF_FFFE, 11'd3, 1'b0}};
        directed_rows[3]  = '{32'h8000_0000, 1'b1, '{33'h1_FFFF_FFFF, 11'd4, 1'b0}};
        directed_rows[4]  = '{32'h0000_0000, 1'b1, '{33'h0_0000_0000, 11'd5, 1'b0}};
        // Alternating bit patterns, near-extremes, duplicates, runs up and down
        directed_rows[5]  = '{32'hFFFF_FFFF, 1'b0, none};
        directed_rows[6]  = '{32'h0000_0001, 1'b0, none};
        directed_rows[7]  = '{32'h5555_5555, 1'b0, none};
        directed_rows[8]  = '{32'hAAAA_AAAA, 1'b0, none};
        directed_rows[9]  = '{32'h0000_0000, 1'b0, none};
        directed_rows[10] = '{32'h0000_0000, 1'b0, none};
        directed_rows[11] = '{32'h7FFF_FFFE, 1'b0, none};
        directed_rows[12] = '{32'h8000_0001, 1'b0, none};
        directed_rows[13] = '{32'h0000_0002, 1'b0, none};
        directed_rows[14] = '{32'h0000_0003, 1'b0, none};
        directed_rows[15] = '{32'h0000_0004, 1'b0, none};
        directed_rows[16] = '{32'h0000_0005, 1'b0, none};
        directed_rows[17] = '{32'hFFFF_FFFB, 1'b0, none};
        directed_rows[18] = '{32'hFFFF_FFFA, 1'b0, none};
        directed_rows[19] = '{32'hFFFF_FFF9, 1'b0, none};
        directed_rows[20] = '{32'h0000_0001, 1'b0, none};
        directed_rows[21] = '{32'hFFFF_FFFF, 1'b0, none};

        // Reset once, asynchronous and active low, released on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
        hold_until_drained();

        // Random part: fills the store to capacity, then runs on with every sample dropped
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                centre = $urandom;
            if (i == 600 || i == 1100 || $urandom_range(0, 299) == 0)
                hold_until_drained();
            send_sample(pick_sample(), 1'b0, none);
        end

        // Drain, then allow for any stray result beyond the last expected one
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outstanding != 0)
            report_mismatch("results never arrived", outstanding, 0);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/rmt_pkg.sv
design/rmt_cell.sv
design/rmt_chain.sv
design/running_median_tracker_unit.sv
design/rmt_checker.sv
sim/running_median_tracker_unit_tb.sv
